### rtl/dvpu_pkg.sv
// Shared types, constants and register codes for the damped Verlet position update core.
package dvpu_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int CFG_W = 24;

  localparam logic [15:0] TIME_STEP_RST = 16'd2163;
  localparam logic [16:0] DAMPING_RST = 17'd64225;
  localparam logic [23:0] AIR_FRICTION_RST = 24'd6554;

  localparam int FORCE_CAP_LOG = 40;
  localparam int FDIV_NUM_W = 57;
  localparam int FDIV_Q_W = 56;
  localparam int MDIV_NUM_W = 89;
  localparam int MDIV_Q_W = 42;

  typedef enum logic [1:0] {
    CFG_TIME_STEP    = 2'd0,
    CFG_DAMPING      = 2'd1,
    CFG_AIR_FRICTION = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SAT       = 2'd1,
    ST_ZERO_MASS = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [31:0] position;
    logic signed [31:0] previous_position;
    logic signed [31:0] internal_force;
    logic signed [31:0] external_force;
    logic        [31:0] mass;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] new_position;
    logic signed [31:0] new_previous_position;
    status_t            status;
  } out_word_t;

  typedef struct packed {
    logic signed [31:0] position;
    logic        [31:0] mass;
    logic signed [32:0] fsum;
    logic        [33:0] dm_mag;
    logic               dneg;
    logic        [31:0] dt2;
  } fdiv_side_t;

  typedef struct packed {
    logic signed [31:0] position;
    logic               mzero;
    logic               fneg;
    logic signed [34:0] damped;
  } mdiv_side_t;

endpackage

### rtl/dvpu_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband carried alongside.
module dvpu_div #(
  parameter int NUM_W = 57,
  parameter int DEN_W = 16,
  parameter int Q_W = 56,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [Q_W-1:0]    quo,
  output logic              ovf,
  output logic [SIDE_W-1:0] side_out
);

  localparam int HI_W = NUM_W - Q_W;
  localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

  logic              vld     [0:Q_W];
  logic [DEN_W-1:0]  rem     [0:Q_W];
  logic [Q_W-1:0]    nq      [0:Q_W];
  logic [DEN_W-1:0]  den_r   [0:Q_W];
  logic              ovf_r   [0:Q_W];
  logic [SIDE_W-1:0] side_r  [0:Q_W];

  logic [CMP_W-1:0] hi_x;
  logic [CMP_W-1:0] den_x;
  logic             hi_ge;

  always_comb begin
    hi_x  = CMP_W'(num[NUM_W-1:Q_W]);
    den_x = CMP_W'(den);
    hi_ge = hi_x >= den_x;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
    end
    if (adv) begin
      rem[0]    <= hi_ge ? '0 : hi_x[DEN_W-1:0];
      nq[0]     <= num[Q_W-1:0];
      den_r[0]  <= den;
      ovf_r[0]  <= hi_ge;
      side_r[0] <= side_in;
    end
  end

  for (genvar k = 1; k <= Q_W; k++) begin : g_stage
    logic [DEN_W:0] trial;
    logic           ge;

    always_comb begin
      trial = {rem[k-1], nq[k-1][Q_W-1]};
      ge    = trial >= {1'b0, den_r[k-1]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (adv) begin
        vld[k] <= vld[k-1];
      end
      if (adv) begin
        rem[k]    <= ge ? DEN_W'(trial - {1'b0, den_r[k-1]}) : trial[DEN_W-1:0];
        nq[k]     <= {nq[k-1][Q_W-2:0], ge};
        den_r[k]  <= den_r[k-1];
        ovf_r[k]  <= ovf_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign out_valid = vld[Q_W];
  assign quo       = nq[Q_W];
  assign ovf       = ovf_r[Q_W];
  assign side_out  = side_r[Q_W];

endmodule

### rtl/damped_verlet_position_update_core.sv
// Top level of the damped Verlet position update core.
// Throughput: one word per cycle while not held by stall; the friction divider (56 stages) and the mass
// divider (42 stages) each retire one quotient bit per stage.
// The whole pipeline holds while the output word waits under stall.
// Reset restores the three registers and clears every valid bit.
module damped_verlet_position_update_core #(
  parameter int FRACTION_BITS = dvpu_pkg::FRACTION_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [1:0]            cfg_index,
  input  logic [dvpu_pkg::CFG_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  dvpu_pkg::in_word_t    in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output dvpu_pkg::out_word_t   out_word
);

  localparam int SHIFT = 32 - FRACTION_BITS;

  logic [15:0] time_step;
  logic [16:0] damping;
  logic [23:0] air_friction;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step    <= dvpu_pkg::TIME_STEP_RST;
      damping      <= dvpu_pkg::DAMPING_RST;
      air_friction <= dvpu_pkg::AIR_FRICTION_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        dvpu_pkg::CFG_TIME_STEP:    time_step    <= cfg_data[15:0];
        dvpu_pkg::CFG_DAMPING:      damping      <= cfg_data[16:0];
        dvpu_pkg::CFG_AIR_FRICTION: air_friction <= cfg_data;
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // stage 1
  logic               s1_valid;
  logic signed [31:0] s1_position;
  logic        [31:0] s1_mass;
  logic signed [32:0] s1_fsum;
  logic        [32:0] s1_ad;
  logic               s1_dneg;
  logic        [15:0] s1_dte;
  logic signed [32:0] d_next;

  always_comb begin
    d_next = 33'(in_word.position) - 33'(in_word.previous_position);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
    if (adv) begin
      s1_position <= in_word.position;
      s1_mass     <= in_word.mass;
      s1_fsum     <= 33'(in_word.internal_force) + 33'(in_word.external_force);
      s1_ad       <= d_next[32] ? 33'(-d_next) : 33'(d_next);
      s1_dneg     <= d_next[32];
      s1_dte      <= (time_step == 16'd0) ? 16'd1 : time_step;
    end
  end

  // stage 2
  logic                            s2_valid;
  logic [dvpu_pkg::FDIV_NUM_W-1:0] s2_fr_num;
  logic [15:0]                     s2_dte;
  dvpu_pkg::fdiv_side_t            s2_side;
  logic [49:0]                     dm_prod;

  always_comb begin
    dm_prod = 50'(s1_ad) * 50'(damping);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
    if (adv) begin
      s2_fr_num        <= dvpu_pkg::FDIV_NUM_W'(s1_ad) * dvpu_pkg::FDIV_NUM_W'(air_friction);
      s2_dte           <= s1_dte;
      s2_side.position <= s1_position;
      s2_side.mass     <= s1_mass;
      s2_side.fsum     <= s1_fsum;
      s2_side.dm_mag   <= dm_prod[49:16];
      s2_side.dneg     <= s1_dneg;
      s2_side.dt2      <= 32'(s1_dte) * 32'(s1_dte);
    end
  end

  logic                          fd_valid;
  logic [dvpu_pkg::FDIV_Q_W-1:0] fd_quo;
  logic                          fd_ovf;
  logic [$bits(dvpu_pkg::fdiv_side_t)-1:0] fd_side_vec;
  dvpu_pkg::fdiv_side_t          fd_side;

  dvpu_div #(
    .NUM_W (dvpu_pkg::FDIV_NUM_W),
    .DEN_W (16),
    .Q_W   (dvpu_pkg::FDIV_Q_W),
    .SIDE_W($bits(dvpu_pkg::fdiv_side_t))
  ) u_fdiv (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (s2_valid),
    .num      (s2_fr_num),
    .den      (s2_dte),
    .side_in  (s2_side),
    .out_valid(fd_valid),
    .quo      (fd_quo),
    .ovf      (fd_ovf),
    .side_out (fd_side_vec)
  );

  assign fd_side = dvpu_pkg::fdiv_side_t'(fd_side_vec);

  // stage 3: total force
  logic                 s3_valid;
  logic signed [57:0]   s3_force;
  dvpu_pkg::fdiv_side_t s3_side;
  logic signed [57:0]   fsum_x;
  logic signed [57:0]   fq_x;

  always_comb begin
    fsum_x = 58'(fd_side.fsum);
    fq_x   = $signed({2'b00, fd_quo});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= fd_valid && !fd_ovf;
    end
    if (adv) begin
      s3_force <= fd_side.dneg ? fsum_x + fq_x : fsum_x - fq_x;
      s3_side  <= fd_side;
    end
  end

  // stage 4: force magnitude
  logic                 s4_valid;
  logic [56:0]          s4_mag;
  logic                 s4_fneg;
  dvpu_pkg::fdiv_side_t s4_side;
  logic signed [57:0]   force_abs;

  always_comb begin
    force_abs = s3_force[57] ? -s3_force : s3_force;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (adv) begin
      s4_valid <= s3_valid;
    end
    if (adv) begin
      s4_mag  <= force_abs[56:0];
      s4_fneg <= s3_force[57];
      s4_side <= s3_side;
    end
  end

  // stage 5: partial products
  logic                 s5_valid;
  logic [63:0]          s5_pp_lo;
  logic [56:0]          s5_pp_hi;
  logic                 s5_fneg;
  dvpu_pkg::fdiv_side_t s5_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (adv) begin
      s5_valid <= s4_valid;
    end
    if (adv) begin
      s5_pp_lo <= 64'(s4_mag[31:0]) * 64'(s4_side.dt2);
      s5_pp_hi <= 57'(s4_mag[56:32]) * 57'(s4_side.dt2);
      s5_fneg  <= s4_fneg;
      s5_side  <= s4_side;
    end
  end

  // stage 6: product, scale, signed damped term
  logic                            s6_valid;
  logic [dvpu_pkg::MDIV_NUM_W-1:0] s6_num;
  logic [31:0]                     s6_mass;
  dvpu_pkg::mdiv_side_t            s6_side;
  logic [dvpu_pkg::MDIV_NUM_W-1:0] prod;
  logic signed [34:0]              dm_x;

  always_comb begin
    prod = {s5_pp_hi, 32'd0} + dvpu_pkg::MDIV_NUM_W'(s5_pp_lo);
    dm_x = $signed({1'b0, s5_side.dm_mag});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else if (adv) begin
      s6_valid <= s5_valid;
    end
    if (adv) begin
      s6_num           <= prod >> SHIFT;
      s6_mass          <= s5_side.mass;
      s6_side.position <= s5_side.position;
      s6_side.mzero    <= s5_side.mass == 32'd0;
      s6_side.fneg     <= s5_fneg;
      s6_side.damped   <= s5_side.dneg ? -dm_x : dm_x;
    end
  end

  logic                          md_valid;
  logic [dvpu_pkg::MDIV_Q_W-1:0] md_quo;
  logic                          md_ovf;
  logic [$bits(dvpu_pkg::mdiv_side_t)-1:0] md_side_vec;
  dvpu_pkg::mdiv_side_t          md_side;

  dvpu_div #(
    .NUM_W (dvpu_pkg::MDIV_NUM_W),
    .DEN_W (32),
    .Q_W   (dvpu_pkg::MDIV_Q_W),
    .SIDE_W($bits(dvpu_pkg::mdiv_side_t))
  ) u_mdiv (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (s6_valid),
    .num      (s6_num),
    .den      (s6_mass),
    .side_in  (s6_side),
    .out_valid(md_valid),
    .quo      (md_quo),
    .ovf      (md_ovf),
    .side_out (md_side_vec)
  );

  assign md_side = dvpu_pkg::mdiv_side_t'(md_side_vec);

  // stage 7: capped, signed force term
  localparam logic [dvpu_pkg::MDIV_Q_W-1:0] CAP_Q =
    dvpu_pkg::MDIV_Q_W'(1) << dvpu_pkg::FORCE_CAP_LOG;

  logic                 s7_valid;
  logic signed [42:0]   s7_term;
  dvpu_pkg::mdiv_side_t s7_side;
  logic [dvpu_pkg::MDIV_Q_W-1:0] tmag;
  logic signed [42:0]   tmag_x;

  always_comb begin
    tmag   = (md_ovf || md_quo > CAP_Q) ? CAP_Q : md_quo;
    tmag_x = $signed({1'b0, tmag});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_valid <= 1'b0;
    end else if (adv) begin
      s7_valid <= md_valid;
    end
    if (adv) begin
      s7_term <= md_side.fneg ? -tmag_x : tmag_x;
      s7_side <= md_side;
    end
  end

  // stage 8: sum, clamp, zero-mass pass-through, output register
  logic signed [44:0] sum;

  always_comb begin
    sum = 45'(s7_side.position) + 45'(s7_side.damped) + 45'(s7_term);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s7_valid;
    end
    if (adv) begin
      out_word.new_previous_position <= s7_side.position;
      if (s7_side.mzero) begin
        out_word.new_position <= s7_side.position;
        out_word.status       <= dvpu_pkg::ST_ZERO_MASS;
      end else if (sum > 45'sd2147483647) begin
        out_word.new_position <= 32'sh7FFFFFFF;
        out_word.status       <= dvpu_pkg::ST_SAT;
      end else if (sum < -45'sd2147483648) begin
        out_word.new_position <= 32'sh80000000;
        out_word.status       <= dvpu_pkg::ST_SAT;
      end else begin
        out_word.new_position <= sum[31:0];
        out_word.status       <= dvpu_pkg::ST_OK;
      end
    end
  end

endmodule

### rtl/dvpu_chk.sv
// Port-level checks for the damped Verlet position update core, bound to the top level.
module dvpu_chk (
  input logic                clk,
  input logic                rst,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input dvpu_pkg::out_word_t out_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("output word changed under stall");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting output word");

  a_zero_mass: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.status == dvpu_pkg::ST_ZERO_MASS |->
      out_word.new_position == out_word.new_previous_position)
    else $error("zero mass word moved the position");

  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.status == dvpu_pkg::ST_SAT |->
      out_word.new_position == 32'sh7FFFFFFF || out_word.new_position == 32'sh80000000)
    else $error("saturated word not at a range limit");

endmodule

bind damped_verlet_position_update_core dvpu_chk u_dvpu_chk (
  .clk      (clk),
  .rst      (rst),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_word (out_word)
);
